>>> hw/rtl/shwr_pkg.sv
// Shared types, constants and codes for the single-wire humidity sensor reader.
// Used by every module of the block; depends on nothing.
package shwr_pkg;

	// Frame and period limits of the sensor protocol.
	localparam int FRAME_BYTES = 5;
	localparam logic [5:0] FRAME_BITS = 6'd40;
	localparam logic [6:0] MAX_PERIODS = 7'd85;
	localparam logic [6:0] FIRST_BIT_PERIOD = 7'd4;

	// Register reset values.
	localparam logic [15:0] START_LOW_RESET = 16'd18000;
	localparam logic [7:0] RELEASE_RESET = 8'd40;
	localparam logic [7:0] THRESHOLD_RESET = 8'd50;
	localparam logic [7:0] TIMEOUT_RESET = 8'd255;

	// Command queue geometry.
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QUEUE_CNT_W-1:0] QUEUE_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);
	localparam logic [QUEUE_PTR_W-1:0] QUEUE_PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_START_LOW = 2'd0,
		CFG_RELEASE = 2'd1,
		CFG_THRESHOLD = 2'd2,
		CFG_TIMEOUT = 2'd3
	} cfg_idx_t;

	// Read sequencer phases.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LOW,
		PH_RELEASE,
		PH_MEASURE
	} phase_t;

	// Kind of work a tick carries.
	typedef enum logic {
		CMD_TICK,
		CMD_START
	} cmd_kind_t;

	// One input tick.
	typedef struct packed {
		logic mode;
		logic pin_level;
		logic [3:0] sensor_tag;
	} in_t;

	// One result per tick.
	typedef struct packed {
		logic drive_low;
		logic busy_res;
		logic done_res;
		logic good;
		logic [7:0] humidity_whole;
		logic [7:0] humidity_tenths;
		logic [7:0] temperature_whole;
		logic [7:0] temperature_tenths;
		logic [3:0] tag_out;
	} out_t;

	// Classified tick as it travels through the queue.
	typedef struct packed {
		cmd_kind_t kind;
		logic level;
		logic [3:0] tag;
	} cmd_t;

	// Queue status seen by both sides.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> hw/rtl/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity sensor reader.
// Depends on shwr_pkg, shwr_front, shwr_queue and shwr_back.
//
// Channel   Handshake                Carries
// sample    sample_valid/stall       mode, pin_level, sensor_tag (one tick)
// result    result_valid/stall       wire drive, busy, done, good, four bytes, tag
// cfg       cfg_valid/cfg_ready      register index and write data
//
// One tick is taken per cycle and gives one result while no result stall holds
// the flow; the sequencer step is combinational, so the rate is one item per clock.
// After a tick transfer, the front stage, the queue entry and the result register
// load in that order before result valid rises.
// Reset puts all but the payload registers at their defaults and the sequencer idle.
// A result stall holds the result register; the queue then fills, and with
// ticks back to back sample_stall rises once the queue is full.
module single_wire_humidity_sensor_reader (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  shwr_pkg::in_t       sample,
	output logic                result_valid,
	input  logic                result_stall,
	output shwr_pkg::out_t      result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	logic push;
	logic pop;
	shwr_pkg::cmd_t push_cmd;
	shwr_pkg::cmd_t head;
	shwr_pkg::q_status_t q_stat;

	// Tick intake and classification.
	shwr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_stat       (q_stat)
	);

	// Command queue.
	shwr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Read sequencer and result register.
	shwr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	// The queue cannot be full and empty at once.
	a_queue_state: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

	// The intake stalls only against a full queue.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> q_stat.full)
		else $error("sample stall without a full queue");

	// A finished read leaves the sequencer idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.done_res) |-> !result.busy_res)
		else $error("done result while still busy");

	// Driving the wire low only happens during a read.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.drive_low) |-> (result.busy_res && !result.done_res))
		else $error("wire driven low outside a read");
`endif

endmodule

>>> hw/rtl/shwr_front.sv
// Front end: takes input ticks, classifies them and pushes them into the queue.
// Depends on shwr_pkg.
module shwr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  shwr_pkg::in_t       sample,
	output logic                push,
	output shwr_pkg::cmd_t      push_cmd,
	input  shwr_pkg::q_status_t q_stat
);

	logic valid_s1;
	shwr_pkg::cmd_t cmd_s1;

	// The stage holds its tick while the queue is full.
	assign sample_stall = valid_s1 && q_stat.full;
	assign push = valid_s1 && !q_stat.full;
	assign push_cmd = cmd_s1;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	// Classify the tick on each transfer.
	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			cmd_s1.kind <= sample.mode ? shwr_pkg::CMD_START : shwr_pkg::CMD_TICK;
			cmd_s1.level <= sample.pin_level;
			cmd_s1.tag <= sample.sensor_tag;
		end
	end

endmodule

>>> hw/rtl/shwr_queue.sv
// Short command queue between the front end and the read sequencer.
// Depends on shwr_pkg.
module shwr_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  shwr_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output shwr_pkg::cmd_t      head,
	output shwr_pkg::q_status_t q_stat
);

	shwr_pkg::cmd_t entries_q [shwr_pkg::QUEUE_DEPTH];
	logic [shwr_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [shwr_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [shwr_pkg::QUEUE_CNT_W-1:0] count_q;

	assign head = entries_q[rd_ptr_q];
	assign q_stat.full = (count_q == shwr_pkg::QUEUE_FULL);
	assign q_stat.empty = (count_q == '0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == shwr_pkg::QUEUE_PTR_LAST) ? '0
					: wr_ptr_q + shwr_pkg::QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == shwr_pkg::QUEUE_PTR_LAST) ? '0
					: rd_ptr_q + shwr_pkg::QUEUE_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + shwr_pkg::QUEUE_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - shwr_pkg::QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

>>> hw/rtl/shwr_back.sv
// Back end: configuration registers, read sequencer and the result register.
// Depends on shwr_pkg.
module shwr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  shwr_pkg::cmd_t      head,
	input  shwr_pkg::q_status_t q_stat,
	output logic                pop,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output logic                result_valid,
	input  logic                result_stall,
	output shwr_pkg::out_t      result
);

	// Configuration registers.
	logic [15:0] start_low_q;
	logic [7:0] release_q;
	logic [7:0] threshold_q;
	logic [7:0] timeout_q;

	// Sequencer state.
	shwr_pkg::phase_t phase_q, phase_d;
	logic [15:0] ticks_q, ticks_d;
	logic prev_q, prev_d;
	logic [7:0] len_q, len_d;
	logic [6:0] idx_q, idx_d;
	logic [5:0] bits_q, bits_d;
	logic [7:0] frame_q [shwr_pkg::FRAME_BYTES];
	logic [7:0] frame_d [shwr_pkg::FRAME_BYTES];
	logic [3:0] tag_q, tag_d;

	// Step results.
	logic drive;
	logic done;
	logic good;
	logic [8:0] limit;
	logic [8:0] len_inc;
	logic one_bit;
	logic [2:0] byte_sel;
	logic [7:0] sum;
	shwr_pkg::out_t res_d;

	logic advance;
	logic result_valid_q;
	shwr_pkg::out_t result_q;

	// The result register takes a new tick when empty or when its transfer completes.
	assign advance = !result_valid_q || !result_stall;
	assign pop = !q_stat.empty && advance;
	assign cfg_ready = 1'b1;
	assign result_valid = result_valid_q;
	assign result = result_q;

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q <= shwr_pkg::START_LOW_RESET;
			release_q <= shwr_pkg::RELEASE_RESET;
			threshold_q <= shwr_pkg::THRESHOLD_RESET;
			timeout_q <= shwr_pkg::TIMEOUT_RESET;
		end else if (cfg_valid) begin
			case (shwr_pkg::cfg_idx_t'(cfg_index))
				shwr_pkg::CFG_START_LOW: start_low_q <= cfg_data;
				shwr_pkg::CFG_RELEASE: release_q <= cfg_data[7:0];
				shwr_pkg::CFG_THRESHOLD: threshold_q <= cfg_data[7:0];
				shwr_pkg::CFG_TIMEOUT: timeout_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// One tick of the sequencer: start, low drive, release, then period timing.
	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		prev_d = prev_q;
		len_d = len_q;
		idx_d = idx_q;
		bits_d = bits_q;
		frame_d = frame_q;
		tag_d = tag_q;
		drive = 1'b0;
		done = 1'b0;
		good = 1'b0;
		limit = (timeout_q == 8'd0) ? 9'd256 : {1'b0, timeout_q};
		len_inc = {1'b0, len_q} + 9'd1;
		one_bit = 1'b0;
		byte_sel = bits_q[5:3];
		sum = 8'd0;

		if (head.kind == shwr_pkg::CMD_START) begin
			phase_d = shwr_pkg::PH_LOW;
			ticks_d = 16'd0;
			prev_d = 1'b1;
			len_d = 8'd0;
			idx_d = 7'd0;
			bits_d = 6'd0;
			frame_d = '{default: 8'd0};
			tag_d = head.tag;
		end

		if (phase_d == shwr_pkg::PH_LOW) begin
			if (ticks_d < start_low_q) begin
				drive = 1'b1;
				ticks_d = ticks_d + 16'd1;
			end else begin
				phase_d = shwr_pkg::PH_RELEASE;
				ticks_d = 16'd0;
			end
		end

		if (phase_d == shwr_pkg::PH_RELEASE) begin
			if (ticks_d < {8'd0, release_q}) begin
				ticks_d = ticks_d + 16'd1;
			end else begin
				phase_d = shwr_pkg::PH_MEASURE;
				ticks_d = 16'd0;
			end
		end else if (phase_d == shwr_pkg::PH_MEASURE) begin
			len_inc = {1'b0, len_d} + 9'd1;
			if (head.level == prev_d) begin
				// Same level: the period grows until it times out.
				if (len_inc >= limit) begin
					done = 1'b1;
				end else begin
					len_d = len_inc[7:0];
				end
			end else begin
				// Level change: periods with an even index from the fifth on carry a data bit, up to forty bits.
				if (idx_d >= shwr_pkg::FIRST_BIT_PERIOD && !idx_d[0]
						&& bits_d < shwr_pkg::FRAME_BITS) begin
					one_bit = (len_d > threshold_q);
					byte_sel = bits_d[5:3];
					frame_d[byte_sel] = {frame_d[byte_sel][6:0], one_bit};
					bits_d = bits_d + 6'd1;
				end
				prev_d = head.level;
				idx_d = idx_d + 7'd1;
				if (idx_d >= shwr_pkg::MAX_PERIODS) begin
					done = 1'b1;
				end else if (limit == 9'd1) begin
					done = 1'b1;
				end else begin
					len_d = 8'd1;
				end
			end
			if (done) begin
				phase_d = shwr_pkg::PH_IDLE;
				sum = frame_d[0] + frame_d[1] + frame_d[2] + frame_d[3];
				good = (bits_d >= shwr_pkg::FRAME_BITS) && (frame_d[4] == sum);
			end
		end

		res_d.drive_low = drive;
		res_d.busy_res = (phase_d != shwr_pkg::PH_IDLE);
		res_d.done_res = done;
		res_d.good = good;
		res_d.humidity_whole = done ? frame_d[0] : 8'd0;
		res_d.humidity_tenths = done ? frame_d[1] : 8'd0;
		res_d.temperature_whole = done ? frame_d[2] : 8'd0;
		res_d.temperature_tenths = done ? frame_d[3] : 8'd0;
		res_d.tag_out = done ? tag_d : 4'd0;
	end

	// Phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= shwr_pkg::PH_IDLE;
		end else if (pop) begin
			phase_q <= phase_d;
		end
	end

	// Counters, frame bytes and tag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= 16'd0;
			prev_q <= 1'b1;
			len_q <= 8'd0;
			idx_q <= 7'd0;
			bits_q <= 6'd0;
			frame_q <= '{default: 8'd0};
			tag_q <= 4'd0;
		end else if (pop) begin
			ticks_q <= ticks_d;
			prev_q <= prev_d;
			len_q <= len_d;
			idx_q <= idx_d;
			bits_q <= bits_d;
			frame_q <= frame_d;
			tag_q <= tag_d;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= !q_stat.empty;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

endmodule

>>> tb/single_wire_humidity_sensor_reader_tb.sv
// Self-checking testbench for the single-wire humidity sensor reader.
// Depends on shwr_pkg and the single_wire_humidity_sensor_reader top level.
// A tick-level predictor of the read sequencer, or the typed result of a directed row, checks every result transfer.
module single_wire_humidity_sensor_reader_tb;
	import shwr_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_ITEMS = 200;
	localparam int HOLD_CYCLES = 120;

	// Directed rows: either a register write or one tick, with the result
	// typed in where it is plain to see.
	typedef struct packed {
		logic is_cfg;
		cfg_idx_t reg_idx;
		logic [15:0] value;
		in_t item;
		logic typed;
		out_t want;
	} plan_row_t;

	localparam out_t QUIET = '0;
	localparam out_t PULLING = '{drive_low: 1'b1, busy_res: 1'b1, default: '0};
	localparam int PLAN_ROWS = 26;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b0, 4'd0}, 1'b1, QUIET},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b1, 4'd15}, 1'b1, QUIET},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b1, 1'b0, 4'd15}, 1'b1, PULLING},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b1, 1'b1, 4'd9}, 1'b1, PULLING},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b1, 4'd0}, 1'b1, PULLING},
		'{1'b1, CFG_START_LOW, 16'd0, '0, 1'b0, '0},
		'{1'b1, CFG_RELEASE, 16'd0, '0, 1'b0, '0},
		'{1'b1, CFG_THRESHOLD, 16'd0, '0, 1'b0, '0},
		'{1'b1, CFG_TIMEOUT, 16'd1, '0, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b1, 1'b1, 4'd5}, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b1, 4'd0}, 1'b1,
			out_t'{done_res: 1'b1, tag_out: 4'd5, default: '0}},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b1, 1'b0, 4'd10}, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b0, 4'd0}, 1'b1,
			out_t'{done_res: 1'b1, tag_out: 4'd10, default: '0}},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b1, 4'd3}, 1'b1, QUIET},
		'{1'b1, CFG_TIMEOUT, 16'd0, '0, 1'b0, '0},
		'{1'b1, CFG_START_LOW, 16'd2, '0, 1'b0, '0},
		'{1'b1, CFG_RELEASE, 16'd1, '0, 1'b0, '0},
		'{1'b1, CFG_THRESHOLD, 16'd255, '0, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b1, 1'b0, 4'd7}, 1'b1, PULLING},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b1, 4'd0}, 1'b1, PULLING},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b0, 4'd1}, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b0, 4'd2}, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b0, 4'd4}, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b1, 4'd8}, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b0, 1'b0, 4'd14}, 1'b0, '0},
		'{1'b0, CFG_START_LOW, 16'd0, in_t'{1'b1, 1'b1, 4'd12}, 1'b1, PULLING}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	in_t sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	out_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	// Predictor copy of the sequencer state and the registers.
	phase_t seq_phase;
	logic [15:0] seq_count;
	logic line_prev;
	logic [7:0] span_len;
	logic [6:0] span_idx;
	logic [5:0] bit_count;
	logic [7:0] frame_data [FRAME_BYTES];
	logic [3:0] tag_latched;
	logic [15:0] set_low;
	logic [7:0] set_release;
	logic [7:0] set_threshold;
	logic [7:0] set_timeout;

	out_t readings_due [$];
	int mismatch_count = 0;
	int sent_items = 0;
	int cycle_count = 0;
	bit idle_on = 1'b0;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	single_wire_humidity_sensor_reader DUT (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("single_wire_humidity_sensor_reader verification failed");
			$finish;
		end
	end

	// Idle length: mostly none, often short, now and then long.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// Shifts one data bit into the frame; bits past the fortieth are dropped.
	function automatic void shift_bit(logic one);
		if (bit_count < FRAME_BITS) begin
			frame_data[bit_count[5:3]] = {frame_data[bit_count[5:3]][6:0], one};
			bit_count = bit_count + 1'b1;
		end
	endfunction

	// Times one measured sample; returns 1 when the read is over.
	function automatic bit track_level(logic lvl);
		int span_limit;
		int grown;
		span_limit = (set_timeout == 8'd0) ? 256 : int'(set_timeout);
		if (lvl == line_prev) begin
			grown = int'(span_len) + 1;
			if (grown >= span_limit)
				return 1'b1;
			span_len = grown[7:0];
			return 1'b0;
		end
		if (span_idx >= FIRST_BIT_PERIOD && !span_idx[0])
			shift_bit(span_len > set_threshold);
		line_prev = lvl;
		span_idx = span_idx + 1'b1;
		if (span_idx >= MAX_PERIODS)
			return 1'b1;
		if (span_limit <= 1)
			return 1'b1;
		span_len = 8'd1;
		return 1'b0;
	endfunction

	// Advances the predicted sequencer by one tick and returns its result.
	function automatic out_t reader_step(in_t item);
		out_t o;
		logic drive;
		logic finished;
		logic [7:0] sum;
		drive = 1'b0;
		finished = 1'b0;
		if (item.mode) begin
			tag_latched = item.sensor_tag;
			seq_phase = PH_LOW;
			seq_count = '0;
			line_prev = 1'b1;
			span_len = '0;
			span_idx = '0;
			bit_count = '0;
			foreach (frame_data[i])
				frame_data[i] = '0;
		end
		if (seq_phase == PH_LOW) begin
			if (seq_count < set_low) begin
				drive = 1'b1;
				seq_count = seq_count + 1'b1;
			end else begin
				seq_phase = PH_RELEASE;
				seq_count = '0;
			end
		end
		if (seq_phase == PH_RELEASE) begin
			if (seq_count < {8'd0, set_release}) begin
				seq_count = seq_count + 1'b1;
			end else begin
				seq_phase = PH_MEASURE;
				seq_count = '0;
			end
		end else if (seq_phase == PH_MEASURE && !drive) begin
			finished = track_level(item.pin_level);
			if (finished)
				seq_phase = PH_IDLE;
		end
		o = '0;
		o.drive_low = drive;
		o.busy_res = (seq_phase != PH_IDLE);
		o.done_res = finished;
		if (finished) begin
			sum = frame_data[0] + frame_data[1] + frame_data[2] + frame_data[3];
			o.good = (bit_count >= FRAME_BITS) && (frame_data[4] == sum);
			o.humidity_whole = frame_data[0];
			o.humidity_tenths = frame_data[1];
			o.temperature_whole = frame_data[2];
			o.temperature_tenths = frame_data[3];
			o.tag_out = tag_latched;
		end
		return o;
	endfunction

	task automatic note_mismatch(input string what, input longint got, input longint want);
		mismatch_count++;
		$display("mismatch at %0t in %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic check_reading(input out_t got, input out_t want);
		if (got.drive_low !== want.drive_low)
			note_mismatch("drive_low", longint'(got.drive_low), longint'(want.drive_low));
		if (got.busy_res !== want.busy_res)
			note_mismatch("busy_res", longint'(got.busy_res), longint'(want.busy_res));
		if (got.done_res !== want.done_res)
			note_mismatch("done_res", longint'(got.done_res), longint'(want.done_res));
		if (got.good !== want.good)
			note_mismatch("good", longint'(got.good), longint'(want.good));
		if (got.humidity_whole !== want.humidity_whole)
			note_mismatch("humidity_whole", longint'(got.humidity_whole),
				longint'(want.humidity_whole));
		if (got.humidity_tenths !== want.humidity_tenths)
			note_mismatch("humidity_tenths", longint'(got.humidity_tenths),
				longint'(want.humidity_tenths));
		if (got.temperature_whole !== want.temperature_whole)
			note_mismatch("temperature_whole", longint'(got.temperature_whole),
				longint'(want.temperature_whole));
		if (got.temperature_tenths !== want.temperature_tenths)
			note_mismatch("temperature_tenths", longint'(got.temperature_tenths),
				longint'(want.temperature_tenths));
		if (got.tag_out !== want.tag_out)
			note_mismatch("tag_out", longint'(got.tag_out), longint'(want.tag_out));
	endtask

	// Result side: check each transfer, then pick the stall for the next edge.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (readings_due.size() == 0)
				note_mismatch("result with nothing pending", longint'(result), 64'd0);
			else
				check_reading(result, readings_due.pop_front());
		end
		if (hold_seen != hold_ticket) begin
			hold_seen = hold_ticket;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
			if (idle_on)
				stall_left = pick_idle();
		end
	end

	// Offers one tick and waits for its transfer; the payload stays put while stalled.
	task automatic send_sample(input in_t item, input bit typed = 1'b0,
			input out_t want = '0);
		int gap;
		out_t predicted;
		gap = idle_on ? pick_idle() : 0;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample <= item;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		predicted = reader_step(item);
		readings_due.push_back(typed ? want : predicted);
		sent_items++;
	endtask

	// Stops offering ticks and waits until every pending result has arrived.
	task automatic settle_readings();
		sample_valid <= 1'b0;
		while (readings_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_setting(input cfg_idx_t which, input logic [15:0] value);
		settle_readings();
		cfg_index <= which;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (which)
			CFG_START_LOW: set_low = value;
			CFG_RELEASE: set_release = value[7:0];
			CFG_THRESHOLD: set_threshold = value[7:0];
			CFG_TIMEOUT: set_timeout = value[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic load_settings(input int low, input int rel, input int thr, input int lim);
		write_setting(CFG_START_LOW, 16'(low));
		write_setting(CFG_RELEASE, 16'(rel));
		write_setting(CFG_THRESHOLD, 16'(thr));
		write_setting(CFG_TIMEOUT, 16'(lim));
	endtask

	function automatic in_t tick_item(logic mode, logic lvl);
		return in_t'{mode, lvl, 4'($urandom_range(0, 15))};
	endfunction

	// Holds the wire at one level for a number of ticks, unless the read has ended.
	task automatic send_span(input logic lvl, input int len);
		for (int i = 0; i < len; i++) begin
			if (seq_phase == PH_IDLE)
				break;
			send_sample(tick_item(1'b0, lvl));
		end
	endtask

	// One sensor answer: start pulse, handshake periods, forty bits and a trailer.
	task automatic send_frame();
		logic [7:0] vals [FRAME_BYTES];
		logic [39:0] pattern;
		int thr;
		int len;
		thr = int'(set_threshold);
		foreach (vals[i])
			vals[i] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 4) != 0)
			vals[4] = vals[0] + vals[1] + vals[2] + vals[3];
		pattern = {vals[0], vals[1], vals[2], vals[3], vals[4]};
		send_sample(tick_item(1'b1, 1'($urandom_range(0, 1))));
		while (seq_phase == PH_LOW || seq_phase == PH_RELEASE)
			send_sample(tick_item(1'b0, 1'($urandom_range(0, 1))));
		send_span(1'b1, $urandom_range(0, 2));
		send_span(1'b0, $urandom_range(1, 3));
		send_span(1'b1, $urandom_range(1, 3));
		send_span(1'b0, $urandom_range(1, 3));
		for (int k = 39; k >= 0; k--) begin
			if (pattern[k])
				len = thr + 1 + $urandom_range(0, 1);
			else
				len = (thr == 0) ? 1 : $urandom_range(1, (thr < 3) ? thr : 3);
			send_span(1'b1, len);
			send_span(1'b0, $urandom_range(1, 2));
		end
		// The high period after the last bit carries a surplus bit.
		send_span(1'b1, $urandom_range(1, 2));
		send_span(1'b0, 1);
	endtask

	// A read with a random wire: mostly cut short or left hanging.
	task automatic send_broken_read();
		send_sample(tick_item(1'b1, 1'($urandom_range(0, 1))));
		for (int i = $urandom_range(10, 60); i > 0; i--) begin
			if (seq_phase == PH_IDLE)
				break;
			send_sample(tick_item(1'b0, 1'($urandom_range(0, 1))));
		end
	endtask

	// Stray ticks, now and then a start among them.
	task automatic send_noise();
		for (int i = $urandom_range(1, 6); i > 0; i--)
			send_sample(tick_item($urandom_range(0, 4) == 0, 1'($urandom_range(0, 1))));
	endtask

	initial begin
		int base;
		int low;
		int rel;
		int thr;
		int lim;
		int r;
		bit first;
		seq_phase = PH_IDLE;
		seq_count = '0;
		line_prev = 1'b1;
		span_len = '0;
		span_idx = '0;
		bit_count = '0;
		foreach (frame_data[i])
			frame_data[i] = '0;
		tag_latched = '0;
		set_low = START_LOW_RESET;
		set_release = RELEASE_RESET;
		set_threshold = THRESHOLD_RESET;
		set_timeout = TIMEOUT_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows.
		idle_on = 1'b1;
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].is_cfg)
				write_setting(PLAN[i].reg_idx, PLAN[i].value);
			else
				send_sample(PLAN[i].item, PLAN[i].typed, PLAN[i].want);
		end

		// A zero timeout lets a period run to 255 before the read aborts.
		load_settings(1, 0, 255, 0);
		send_frame();

		// Random phases, each with its own register setting.
		base = sent_items;
		first = 1'b1;
		while (sent_items - base < RANDOM_ITEMS) begin
			low = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(4, 12);
			rel = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 4) : $urandom_range(5, 15);
			thr = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
			r = $urandom_range(0, 99);
			if (r < 70)
				lim = thr + $urandom_range(3, 8);
			else if (r < 85)
				lim = 0;
			else
				lim = $urandom_range(1, thr + 2);
			load_settings(low, rel, thr, lim);
			idle_on = ($urandom_range(0, 3) != 0);
			// Receiver holds off while ticks keep coming, so the input backs up.
			if (first) begin
				hold_ticket++;
				first = 1'b0;
			end
			for (int n = $urandom_range(1, 3); n > 0 && sent_items - base < RANDOM_ITEMS;
					n--) begin
				r = $urandom_range(0, 9);
				if (r == 0)
					send_noise();
				else if (r == 1)
					send_broken_read();
				else
					send_frame();
			end
		end

		settle_readings();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && readings_due.size() == 0)
			$display("single_wire_humidity_sensor_reader verification clean");
		else
			$display("single_wire_humidity_sensor_reader verification failed");
		$finish;
	end

endmodule
